/* rtl/core/wppf_pkg.sv */
`timescale 1ns / 1ps

package wppf_pkg;

    // table and coordinate sizes
    localparam int MAX_WAYPOINTS = 1024;
    localparam int COORD_BITS    = 24;
    localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
    localparam int ENTRY_W       = 3 * COORD_BITS;

    // keep radius register
    localparam int                  THRESH_W     = 24;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(10000);
    localparam int                  TSQ_W        = 2 * THRESH_W;

    // distance arithmetic
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;

    // stream widths, tdata packed to whole bytes
    localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + CNT_W + 7) / 8) * 8;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // request commands
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clear;
        logic append;
        logic scan_start;
        logic issue;
        logic flush;
    } wppf_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             empty;
        logic             issue_last;
        logic             res_valid;
        logic             res_hit;
        logic             res_last;
    } wppf_sts_t;

endpackage

/* rtl/core/wppf_datapath.sv */
`timescale 1ns / 1ps

module wppf_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wppf_pkg::wppf_ctl_t                     ctl,
    output wppf_pkg::wppf_sts_t                     sts,
    input  logic signed [wppf_pkg::COORD_BITS-1:0]  x_coord,
    input  logic signed [wppf_pkg::COORD_BITS-1:0]  y_coord,
    input  logic signed [wppf_pkg::COORD_BITS-1:0]  z_coord,
    input  logic                                    cfg_valid,
    input  logic [wppf_pkg::THRESH_W-1:0]           cfg_data
);

    import wppf_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    // waypoint table, x in the low bits
    logic [ENTRY_W-1:0] mem [MAX_WAYPOINTS];

    logic [CNT_W-1:0]    count_reg;
    logic [THRESH_W-1:0] thr_reg;
    logic [TSQ_W-1:0]    thr_sq_reg;
    logic [ADDR_W-1:0]   scan_addr_reg;

    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;

    logic [ENTRY_W-1:0] rd_reg;
    logic [DIFF_W-1:0]  ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]    sx_reg, sy_reg, sz_reg;
    logic               hit_reg;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;

    logic [SUM_W-1:0] dist_sq;
    logic             issue_last;

    assign issue_last = (CNT_W'(scan_addr_reg) == count_reg - CNT_W'(1));
    assign dist_sq    = SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);

    always_comb
    begin
        sts.count      = count_reg;
        sts.full       = (count_reg == CNT_W'(MAX_WAYPOINTS));
        sts.empty      = (count_reg == '0);
        sts.issue_last = issue_last;
        sts.res_valid  = s4_vld_reg;
        sts.res_hit    = hit_reg;
        sts.res_last   = s4_last_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            thr_reg       <= THRESH_RESET;
            scan_addr_reg <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_last_reg   <= 1'b0;
            s3_last_reg   <= 1'b0;
            s4_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                thr_reg <= cfg_data;

            if (ctl.clear)
                count_reg <= '0;
            else if (ctl.append)
                count_reg <= count_reg + CNT_W'(1);

            if (ctl.scan_start)
                scan_addr_reg <= '0;
            else if (ctl.issue)
                scan_addr_reg <= scan_addr_reg + ADDR_W'(1);

            s1_last_reg <= issue_last;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;

            if (ctl.flush)
            begin
                s1_vld_reg <= 1'b0;
                s2_vld_reg <= 1'b0;
                s3_vld_reg <= 1'b0;
                s4_vld_reg <= 1'b0;
            end
            else
            begin
                s1_vld_reg <= ctl.issue;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.append)
            mem[count_reg[ADDR_W-1:0]] <= {pz_reg, py_reg, px_reg};
        if (ctl.issue)
            rd_reg <= mem[scan_addr_reg];
    end

    // distance pipeline: abs diff, squares, sum and compare
    always_ff @(posedge clk)
    begin
        thr_sq_reg <= TSQ_W'(thr_reg) * TSQ_W'(thr_reg);

        if (ctl.capture)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
            pz_reg <= z_coord;
        end

        ax_reg <= abs_diff(rd_reg[COORD_BITS-1:0], px_reg);
        ay_reg <= abs_diff(rd_reg[2*COORD_BITS-1:COORD_BITS], py_reg);
        az_reg <= abs_diff(rd_reg[3*COORD_BITS-1:2*COORD_BITS], pz_reg);

        sx_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sy_reg <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sz_reg <= SQ_W'(az_reg) * SQ_W'(az_reg);

        hit_reg <= (dist_sq <= SUM_W'(thr_sq_reg));
    end

endmodule

/* rtl/core/wppf_ctrl.sv */
`timescale 1ns / 1ps

module wppf_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wppf_pkg::CMD_W-1:0]      cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            keep,
    output logic [wppf_pkg::STATUS_W-1:0]   status,
    output logic [wppf_pkg::CNT_W-1:0]      waypoint_count,
    output wppf_pkg::wppf_ctl_t             ctl,
    input  wppf_pkg::wppf_sts_t             sts
);

    import wppf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic                keep_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                issued_all_reg;
    logic                m_valid_reg;
    logic                m_keep_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [CNT_W-1:0]    m_count_reg;

    logic in_accept;
    logic stop;
    logic out_free;

    assign s_tready       = (state_reg == ST_IDLE);
    assign in_accept      = s_tvalid & s_tready;
    assign stop           = sts.res_valid & (sts.res_hit | sts.res_last);
    assign out_free       = ~m_valid_reg | m_tready;
    assign m_tvalid       = m_valid_reg;
    assign keep           = m_keep_reg;
    assign status         = m_status_reg;
    assign waypoint_count = m_count_reg;

    always_comb
    begin
        ctl.capture    = in_accept;
        ctl.clear      = (state_reg == ST_EXEC) && (cmd_reg == CMD_CLEAR);
        ctl.append     = (state_reg == ST_EXEC) && (cmd_reg == CMD_APPEND) && !sts.full;
        ctl.scan_start = (state_reg == ST_EXEC) && (cmd_reg == CMD_CLASSIFY) && !sts.empty;
        ctl.issue      = (state_reg == ST_SCAN) && !issued_all_reg && !stop;
        ctl.flush      = (state_reg == ST_SCAN) && stop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_CLEAR;
            keep_reg       <= 1'b0;
            status_reg     <= STATUS_OK;
            issued_all_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_keep_reg     <= 1'b0;
            m_status_reg   <= STATUS_OK;
            m_count_reg    <= '0;
        end
        else
        begin
            if ((state_reg == ST_RESP) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    keep_reg   <= 1'b0;
                    status_reg <= STATUS_OK;
                    state_reg  <= ST_RESP;
                    if (cmd_reg == CMD_APPEND)
                    begin
                        if (sts.full)
                            status_reg <= STATUS_FULL;
                    end
                    else if (cmd_reg == CMD_CLASSIFY)
                    begin
                        if (sts.empty)
                            status_reg <= STATUS_EMPTY;
                        else
                        begin
                            issued_all_reg <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (ctl.issue && sts.issue_last)
                        issued_all_reg <= 1'b1;
                    if (stop)
                    begin
                        keep_reg  <= sts.res_hit;
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        m_keep_reg   <= keep_reg;
                        m_status_reg <= status_reg;
                        m_count_reg  <= sts.count;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/core/waypoint_proximity_point_filter.sv */
`timescale 1ns / 1ps

// waypoint proximity point filter: holds up to 1024 waypoints and answers one
// request at a time. s_tuser carries the command (clear, append, classify),
// s_tdata the x/y/z coordinates in centimetres. every request gives exactly
// one result: keep (point lies within the keep radius of some waypoint,
// boundary included), a status code (ok, table full, no waypoints) and the
// waypoint count after the request. classify walks the table in order until the
// first hit (all of it when none is near), the single table read port
// feeding one squared-distance compare per cycle through a four-stage
// pipeline. a new request is taken while the previous result still waits in
// the output register. the user must write the radius on the cfg port only
// while no request is in progress; the block does not enforce this. the radius
// resets to 10000 (100 m)
module waypoint_proximity_point_filter (
    input  logic                                clk,
    input  logic                                rst_n,

    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wppf_pkg::S_TDATA_W-1:0]      s_tdata,   // x_coord, y_coord, z_coord
    input  logic [wppf_pkg::CMD_W-1:0]          s_tuser,   // cmd

    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wppf_pkg::M_TDATA_W-1:0]      m_tdata,   // keep, waypoint_count, zero pad
    output logic [wppf_pkg::STATUS_W-1:0]       m_tuser,   // status

    // keep radius register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wppf_pkg::THRESH_W-1:0]       cfg_data   // distance_threshold
);

    import wppf_pkg::*;

    wppf_ctl_t           ctl;
    wppf_sts_t           sts;
    logic                keep;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    waypoint_count;

    // radius writes are always taken
    assign cfg_ready = 1'b1;

    // result packing, keep in bit 0
    assign m_tdata = M_TDATA_W'({waypoint_count, keep});
    assign m_tuser = status;

    wppf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .cmd            (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .keep           (keep),
        .status         (status),
        .waypoint_count (waypoint_count),
        .ctl            (ctl),
        .sts            (sts)
    );

    // coordinates unpacked from the request, x lowest
    wppf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .x_coord   (s_tdata[COORD_BITS-1:0]),
        .y_coord   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .z_coord   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data)
    );

endmodule
